// ----- hdl/uodo_pkg.sv -----
// Package for the usage odometer: command and register index codes,
// field widths and the constants of the constant dividers.
// No dependencies.
package uodo_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_START      = 2'd1,
    CMD_SAVE       = 2'd2,
    CMD_FORCE_SAVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_MIN_SPEED         = 3'd0,
    CFG_DISTANCE_INTERVAL = 3'd1,
    CFG_TIME_INTERVAL     = 3'd2,
    CFG_INITIAL_DISTANCE  = 3'd3,
    CFG_INITIAL_TIME      = 3'd4
  } cfg_index_t;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  localparam int SPEED_BITS    = 14;
  localparam int MS_BITS       = 16;
  localparam int INTERVAL_BITS = 20;
  localparam int DIST_OUT_BITS = 48;
  localparam int TIME_OUT_BITS = 40;

  localparam int DISTANCE_BITS_DEF = 48;
  localparam int TIME_BITS_DEF     = 40;

  localparam logic [SPEED_BITS-1:0]    MIN_SPEED_RST   = 14'd50;
  localparam logic [INTERVAL_BITS-1:0] DIST_INTVL_RST  = 20'd1000;
  localparam logic [INTERVAL_BITS-1:0] TIME_INTVL_RST  = 20'd600;

  // speed * ms product: 14 x 16 bits
  localparam int PROD_BITS = SPEED_BITS + MS_BITS;

  // 360000 units per metre = 2^6 * 5625
  localparam int METRE_LO_BITS = 6;
  localparam int METRE_HI_BITS = PROD_BITS - METRE_LO_BITS;      // 24
  localparam logic [23:0] METRE_DIV = 24'd5625;
  localparam int METRE_SHIFT = 36;
  localparam logic [23:0] METRE_RECIP = 24'((64'd1 << METRE_SHIFT) / 5625);
  localparam int METRE_Q_BITS = 12;                              // quotient < 2983
  localparam int METRE_R_BITS = 19;                              // remainder < 360000
  localparam logic [19:0] UNITS_PER_METRE = 20'd360000;

  // 1000 ms per second = 2^3 * 125
  localparam int MS_LO_BITS = 3;
  localparam int MS_HI_BITS = MS_BITS - MS_LO_BITS;              // 13
  localparam logic [13:0] SEC_DIV = 14'd125;
  localparam int SEC_SHIFT = 20;
  localparam logic [13:0] SEC_RECIP = 14'((64'd1 << SEC_SHIFT) / 125);
  localparam int SEC_Q_BITS = 7;                                 // quotient < 67
  localparam int SEC_R_BITS = 10;                                // remainder < 1000
  localparam logic [10:0] MS_PER_SECOND = 11'd1000;

endpackage

// ----- hdl/usage_odometer_with_save_flag_top.sv -----
// Usage odometer top level: divider pipeline, state update stage and result register.
// Depends on uodo_pkg.
//
// Usage odometer. Accepts one item per clock (cmd, speed, elapsed_ms) while the output
// side is not stalled and returns exactly one result per item, in order. A start item
// loads both totals from initial_distance / initial_time and enables counting; tick
// items at or above min_speed after a start add speed * ms into an exact metre
// remainder (360000 units per metre) and ms into a second remainder; save items act
// when forced or with the pending flag set, clear the flag and, once started, mark
// the totals to be stored. Sustained rate is one item per cycle while the output
// side is not stalled: all state lives in the final update stage, which does a small
// remainder add, one saturating add per total and the interval compare. The division
// of speed * ms and of ms by their constants is done ahead of it in a four stage
// pipeline (multiply, reciprocal estimate, remainder, correction) that only sees the
// item, never the state. Every stage has its own valid bit and loads whenever it is
// empty or its successor moves, so bubbles collapse and items are still taken while
// a result waits in the output register. Configuration is written through
// cfg_we / cfg_index / cfg_data and is only expected to change while idle.
module usage_odometer_with_save_flag_top #(
  parameter int DISTANCE_BITS = uodo_pkg::DISTANCE_BITS_DEF,
  parameter int TIME_BITS     = uodo_pkg::TIME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [uodo_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [uodo_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             cmd,
  input  logic [uodo_pkg::SPEED_BITS-1:0]        speed,
  input  logic [uodo_pkg::MS_BITS-1:0]           elapsed_ms,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [uodo_pkg::DIST_OUT_BITS-1:0]     distance_total,
  output logic [uodo_pkg::TIME_OUT_BITS-1:0]     time_total,
  output logic                                   save_pending,
  output logic                                   store_now
);
  import uodo_pkg::*;

  localparam int DW  = DISTANCE_BITS;
  localparam int TW  = TIME_BITS;
  localparam int DXW = (DW > DIST_OUT_BITS) ? DW : DIST_OUT_BITS;
  localparam int TXW = (TW > TIME_OUT_BITS) ? TW : TIME_OUT_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SPEED_BITS-1:0]    min_speed;
  logic [INTERVAL_BITS-1:0] distance_interval;
  logic [INTERVAL_BITS-1:0] time_interval;
  logic [DIST_OUT_BITS-1:0] initial_distance;
  logic [TIME_OUT_BITS-1:0] initial_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed         <= MIN_SPEED_RST;
      distance_interval <= DIST_INTVL_RST;
      time_interval     <= TIME_INTVL_RST;
      initial_distance  <= '0;
      initial_time      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MIN_SPEED:         min_speed         <= cfg_data[SPEED_BITS-1:0];
        CFG_DISTANCE_INTERVAL: distance_interval <= cfg_data[INTERVAL_BITS-1:0];
        CFG_TIME_INTERVAL:     time_interval     <= cfg_data[INTERVAL_BITS-1:0];
        CFG_INITIAL_DISTANCE:  initial_distance  <= cfg_data[DIST_OUT_BITS-1:0];
        CFG_INITIAL_TIME:      initial_time      <= cfg_data[TIME_OUT_BITS-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic out_free, e_ready, d_ready, c_ready, b_ready;

  assign out_free = !out_valid || out_ready;
  assign e_ready  = !e_valid || out_free;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign in_ready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (in_ready) a_valid <= in_valid;
      if (b_ready)  b_valid <= a_valid;
      if (c_ready)  c_valid <= b_valid;
      if (d_ready)  d_valid <= c_valid;
      if (e_ready)  e_valid <= d_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------------------
  cmd_t                  a_cmd;
  logic [SPEED_BITS-1:0] a_speed;
  logic [MS_BITS-1:0]    a_ms;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_cmd   <= cmd_t'(cmd);
      a_speed <= speed;
      a_ms    <= elapsed_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: speed * ms
  // ---------------------------------------------------------------------------
  cmd_t                  b_cmd;
  logic [SPEED_BITS-1:0] b_speed;
  logic [MS_BITS-1:0]    b_ms;
  logic [PROD_BITS-1:0]  b_prod;

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_cmd   <= a_cmd;
      b_speed <= a_speed;
      b_ms    <= a_ms;
      b_prod  <= PROD_BITS'(a_speed) * PROD_BITS'(a_ms);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: quotient estimates by reciprocal multiply (low or exact)
  // ---------------------------------------------------------------------------
  logic [2*METRE_HI_BITS-1:0] metre_recip_prod;
  logic [MS_HI_BITS+13:0]     sec_recip_prod;

  assign metre_recip_prod = (2*METRE_HI_BITS)'(b_prod[PROD_BITS-1:METRE_LO_BITS]) *
                            (2*METRE_HI_BITS)'(METRE_RECIP);
  assign sec_recip_prod   = (MS_HI_BITS+14)'(b_ms[MS_BITS-1:MS_LO_BITS]) *
                            (MS_HI_BITS+14)'(SEC_RECIP);

  cmd_t                     c_cmd;
  logic [SPEED_BITS-1:0]    c_speed;
  logic                     c_ms_zero;
  logic [METRE_HI_BITS-1:0] c_prod_hi;
  logic [METRE_LO_BITS-1:0] c_prod_lo;
  logic [METRE_Q_BITS-1:0]  c_qd;
  logic [MS_HI_BITS-1:0]    c_ms_hi;
  logic [MS_LO_BITS-1:0]    c_ms_lo;
  logic [SEC_Q_BITS-1:0]    c_qt;

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_cmd     <= b_cmd;
      c_speed   <= b_speed;
      c_ms_zero <= (b_ms == '0);
      c_prod_hi <= b_prod[PROD_BITS-1:METRE_LO_BITS];
      c_prod_lo <= b_prod[METRE_LO_BITS-1:0];
      c_qd      <= metre_recip_prod[METRE_SHIFT +: METRE_Q_BITS];
      c_ms_hi   <= b_ms[MS_BITS-1:MS_LO_BITS];
      c_ms_lo   <= b_ms[MS_LO_BITS-1:0];
      c_qt      <= sec_recip_prod[SEC_SHIFT +: SEC_Q_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: remainder against the estimate (below twice the divisor)
  // ---------------------------------------------------------------------------
  logic [METRE_HI_BITS-1:0] metre_rem_raw;
  logic [MS_HI_BITS-1:0]    sec_rem_raw;

  assign metre_rem_raw = c_prod_hi - METRE_HI_BITS'(c_qd) * METRE_DIV;
  assign sec_rem_raw   = c_ms_hi - MS_HI_BITS'(c_qt) * MS_HI_BITS'(SEC_DIV);

  cmd_t                     d_cmd;
  logic [SPEED_BITS-1:0]    d_speed;
  logic                     d_ms_zero;
  logic [METRE_Q_BITS-1:0]  d_qd;
  logic [13:0]              d_rd;
  logic [METRE_LO_BITS-1:0] d_prod_lo;
  logic [SEC_Q_BITS-1:0]    d_qt;
  logic [7:0]               d_rt;
  logic [MS_LO_BITS-1:0]    d_ms_lo;

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_cmd     <= c_cmd;
      d_speed   <= c_speed;
      d_ms_zero <= c_ms_zero;
      d_qd      <= c_qd;
      d_rd      <= metre_rem_raw[13:0];
      d_prod_lo <= c_prod_lo;
      d_qt      <= c_qt;
      d_rt      <= sec_rem_raw[7:0];
      d_ms_lo   <= c_ms_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: one correction step, rebuild full remainders
  // ---------------------------------------------------------------------------
  logic       rd_over, rt_over;
  logic [13:0] rd_fix;
  logic [7:0]  rt_fix;

  assign rd_over = (d_rd >= METRE_DIV[13:0]);
  assign rt_over = (d_rt >= SEC_DIV[7:0]);
  assign rd_fix  = rd_over ? (d_rd - METRE_DIV[13:0]) : d_rd;
  assign rt_fix  = rt_over ? (d_rt - SEC_DIV[7:0]) : d_rt;

  cmd_t                    e_cmd;
  logic [SPEED_BITS-1:0]   e_speed;
  logic                    e_ms_zero;
  logic [METRE_Q_BITS-1:0] e_qd;
  logic [METRE_R_BITS-1:0] e_rd;
  logic [SEC_Q_BITS-1:0]   e_qt;
  logic [SEC_R_BITS-1:0]   e_rt;

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_cmd     <= d_cmd;
      e_speed   <= d_speed;
      e_ms_zero <= d_ms_zero;
      e_qd      <= d_qd + METRE_Q_BITS'(rd_over);
      e_rd      <= {rd_fix[METRE_R_BITS-METRE_LO_BITS-1:0], d_prod_lo};
      e_qt      <= d_qt + SEC_Q_BITS'(rt_over);
      e_rt      <= {rt_fix[SEC_R_BITS-MS_LO_BITS-1:0], d_ms_lo};
    end
  end

  // ---------------------------------------------------------------------------
  // State update stage
  // ---------------------------------------------------------------------------
  logic [DW-1:0]           distance_count, distance_count_next;
  logic [TW-1:0]           time_count, time_count_next;
  logic [DW-1:0]           saved_distance, saved_distance_next;
  logic [TW-1:0]           saved_time, saved_time_next;
  logic [METRE_R_BITS-1:0] metre_remainder, metre_remainder_next;
  logic [SEC_R_BITS-1:0]   ms_remainder, ms_remainder_next;
  logic                    pending_flag, pending_flag_next;
  logic                    started_flag, started_flag_next;
  logic                    stored;

  // tick arithmetic
  logic                    moving;
  logic [METRE_R_BITS:0]   metre_sum;
  logic                    metre_carry;
  logic [METRE_Q_BITS-1:0] metres;
  logic [SEC_R_BITS:0]     ms_sum;
  logic                    sec_carry;
  logic [SEC_Q_BITS-1:0]   secs;
  logic [DW:0]             dist_sum;
  logic [TW:0]             time_sum;
  logic [DW-1:0]           dist_added;
  logic [TW-1:0]           time_added;
  logic                    interval_hit;

  // start load, saturated to counter maximum
  logic [DXW-1:0]          init_d_ext;
  logic [TXW-1:0]          init_t_ext;
  logic [DW-1:0]           start_dist;
  logic [TW-1:0]           start_time;

  assign moving = started_flag && (e_cmd == CMD_TICK) && !e_ms_zero &&
                  (e_speed >= min_speed);

  assign metre_sum   = (METRE_R_BITS+1)'(metre_remainder) + (METRE_R_BITS+1)'(e_rd);
  assign metre_carry = (metre_sum >= UNITS_PER_METRE);
  assign metres      = e_qd + METRE_Q_BITS'(metre_carry);

  assign ms_sum    = (SEC_R_BITS+1)'(ms_remainder) + (SEC_R_BITS+1)'(e_rt);
  assign sec_carry = (ms_sum >= MS_PER_SECOND);
  assign secs      = e_qt + SEC_Q_BITS'(sec_carry);

  assign dist_sum   = {1'b0, distance_count} + (DW+1)'(metres);
  assign time_sum   = {1'b0, time_count} + (TW+1)'(secs);
  assign dist_added = dist_sum[DW] ? {DW{1'b1}} : dist_sum[DW-1:0];
  assign time_added = time_sum[TW] ? {TW{1'b1}} : time_sum[TW-1:0];

  // counts never fall below the saved snapshot, so the differences do not wrap
  assign interval_hit = ((dist_added - saved_distance) >= DW'(distance_interval)) ||
                        ((time_added - saved_time) >= TW'(time_interval));

  assign init_d_ext = DXW'(initial_distance);
  assign init_t_ext = TXW'(initial_time);
  assign start_dist = (init_d_ext > DXW'({DW{1'b1}})) ? {DW{1'b1}} : DW'(init_d_ext);
  assign start_time = (init_t_ext > TXW'({TW{1'b1}})) ? {TW{1'b1}} : TW'(init_t_ext);

  always_comb begin
    distance_count_next  = distance_count;
    time_count_next      = time_count;
    saved_distance_next  = saved_distance;
    saved_time_next      = saved_time;
    metre_remainder_next = metre_remainder;
    ms_remainder_next    = ms_remainder;
    pending_flag_next    = pending_flag;
    started_flag_next    = started_flag;
    stored               = 1'b0;
    unique case (e_cmd)
      CMD_TICK: begin
        if (moving) begin
          distance_count_next  = dist_added;
          time_count_next      = time_added;
          metre_remainder_next = metre_carry ?
                                 METRE_R_BITS'(metre_sum - (METRE_R_BITS+1)'(UNITS_PER_METRE)) :
                                 metre_sum[METRE_R_BITS-1:0];
          ms_remainder_next    = sec_carry ?
                                 SEC_R_BITS'(ms_sum - (SEC_R_BITS+1)'(MS_PER_SECOND)) :
                                 ms_sum[SEC_R_BITS-1:0];
          if (interval_hit) pending_flag_next = 1'b1;
        end
      end
      CMD_START: begin
        distance_count_next  = start_dist;
        time_count_next      = start_time;
        saved_distance_next  = start_dist;
        saved_time_next      = start_time;
        metre_remainder_next = '0;
        ms_remainder_next    = '0;
        pending_flag_next    = 1'b0;
        started_flag_next    = 1'b1;
      end
      CMD_SAVE, CMD_FORCE_SAVE: begin
        // save if pending only acts with the flag set; forced save always does
        if (pending_flag || (e_cmd == CMD_FORCE_SAVE)) begin
          pending_flag_next = 1'b0;
          if (started_flag) begin
            saved_distance_next = distance_count;
            saved_time_next     = time_count;
            stored              = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State and result register move together when the item leaves stage E
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      distance_count  <= '0;
      time_count      <= '0;
      saved_distance  <= '0;
      saved_time      <= '0;
      metre_remainder <= '0;
      ms_remainder    <= '0;
      pending_flag    <= 1'b0;
      started_flag    <= 1'b0;
    end else if (out_free) begin
      out_valid <= e_valid;
      if (e_valid) begin
        distance_count  <= distance_count_next;
        time_count      <= time_count_next;
        saved_distance  <= saved_distance_next;
        saved_time      <= saved_time_next;
        metre_remainder <= metre_remainder_next;
        ms_remainder    <= ms_remainder_next;
        pending_flag    <= pending_flag_next;
        started_flag    <= started_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && e_valid) begin
      distance_total <= DIST_OUT_BITS'(distance_count_next);
      time_total     <= TIME_OUT_BITS'(time_count_next);
      save_pending   <= pending_flag_next;
      store_now      <= stored;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_metre_rem_range: assert property (@(posedge clk) disable iff (rst)
    METRE_R_BITS'(metre_remainder) < METRE_R_BITS'(UNITS_PER_METRE))
    else $error("metre remainder out of range");

  a_ms_rem_range: assert property (@(posedge clk) disable iff (rst)
    SEC_R_BITS'(ms_remainder) < SEC_R_BITS'(MS_PER_SECOND))
    else $error("ms remainder out of range");

  a_saved_not_ahead: assert property (@(posedge clk) disable iff (rst)
    (saved_distance <= distance_count) && (saved_time <= time_count))
    else $error("saved snapshot ahead of running totals");

  a_store_needs_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && store_now) |-> started_flag)
    else $error("store reported before start");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (a_valid && b_valid && c_valid && d_valid && e_valid && out_valid))
    else $error("input stalled with an empty stage");

endmodule
